@@ hw/rtl/jsu_pkg.sv @@
// Shared types, constants and the UTF-8 encoder for the JSON string unescaper.
// No dependencies; jsu_decode, jsu_rsp_buf and the top level import it.
package jsu_pkg;

   // Result buffer sizing
   localparam int MaxRes = 6;
   localparam int CountW = $clog2(MaxRes + 1);
   localparam int IdxW   = $clog2(MaxRes);

   // Result kinds
   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // Error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_EXP_STRING = 3'd1;
   localparam logic [2:0] ERR_UNTERM_STR = 3'd2;
   localparam logic [2:0] ERR_UNTERM_ESC = 3'd3;
   localparam logic [2:0] ERR_BAD_UESC   = 3'd4;
   localparam logic [2:0] ERR_BAD_ESC    = 3'd5;
   localparam logic [2:0] ERR_CTRL_CHAR  = 3'd6;

   // UTF-8 lead and continuation markers
   localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
   localparam logic [7:0] UTF8_CONT  = 8'h80;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] out_kind;
      logic [2:0] error_code;
   } jsu_res_type;

   // All results caused by one transaction, slot 0 first
   typedef struct packed {
      logic [CountW-1:0]            count;
      jsu_res_type [MaxRes-1:0]     slot;
   } jsu_list_type;

   // Status of the result buffer seen by the top level
   typedef struct packed {
      logic valid;
      logic last;
      logic can_load;
   } jsu_buf_status_type;

   typedef struct packed {
      logic [2:0]      len;
      logic [3:0][7:0] bytes;
   } jsu_utf8_type;

   // Encode one code point (up to 21 bits) as 1 to 4 UTF-8 bytes
   function automatic jsu_utf8_type jsu_utf8(input logic [20:0] cp);
      jsu_utf8_type r;
      r.bytes = '0;
      if (cp < 21'h80) begin
         r.len      = 3'd1;
         r.bytes[0] = cp[7:0];
      end else if (cp < 21'h800) begin
         r.len      = 3'd2;
         r.bytes[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
         r.bytes[1] = UTF8_CONT | {2'b00, cp[5:0]};
      end else if (cp < 21'h10000) begin
         r.len      = 3'd3;
         r.bytes[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
         r.bytes[1] = UTF8_CONT | {2'b00, cp[11:6]};
         r.bytes[2] = UTF8_CONT | {2'b00, cp[5:0]};
      end else begin
         r.len      = 3'd4;
         r.bytes[0] = UTF8_LEAD4 | {5'b00000, cp[20:18]};
         r.bytes[1] = UTF8_CONT | {2'b00, cp[17:12]};
         r.bytes[2] = UTF8_CONT | {2'b00, cp[11:6]};
         r.bytes[3] = UTF8_CONT | {2'b00, cp[5:0]};
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/jsu_req_if.sv @@
// Input channel: one raw byte or an end-of-input marker per transaction.
// No dependencies.
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_input;

   modport source (output valid, output in_byte, output end_of_input, input ready);
   modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

@@ hw/rtl/jsu_rsp_if.sv @@
// Result channel: one decoded byte, completion or error per transaction.
// No dependencies.
interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic [1:0] out_kind;
   logic [2:0] error_code;
   logic       last;

   modport source (output valid, output out_byte, output out_kind, output error_code,
                   output last, input ready);
   modport sink   (input valid, input out_byte, input out_kind, input error_code,
                   input last, output ready);
endinterface

@@ hw/rtl/jsu_decode.sv @@
// Parser state and single-pass decode of one input transaction into its result list.
// Depends on jsu_pkg.
module jsu_decode
   import jsu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic [7:0]   in_byte,
   input  logic         end_of_input,
   output jsu_list_type list
);

   // Parser modes
   localparam logic [2:0] M_WAIT = 3'd0;
   localparam logic [2:0] M_STR  = 3'd1;
   localparam logic [2:0] M_ESC  = 3'd2;
   localparam logic [2:0] M_HEX  = 3'd3;
   localparam logic [2:0] M_LOOK = 3'd4;
   localparam logic [2:0] M_DONE = 3'd5;
   localparam logic [2:0] M_ERR  = 3'd6;

   // Kinds of the main result of a transaction
   localparam logic [2:0] MK_NONE = 3'd0;
   localparam logic [2:0] MK_RAW  = 3'd1;
   localparam logic [2:0] MK_CP   = 3'd2;
   localparam logic [2:0] MK_DONE = 3'd3;
   localparam logic [2:0] MK_ERR  = 3'd4;

   // Characters
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_LOWER_B = 8'h62;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_LOWER_N = 8'h6E;
   localparam logic [7:0] CH_LOWER_R = 8'h72;
   localparam logic [7:0] CH_LOWER_T = 8'h74;
   localparam logic [7:0] CH_LOWER_U = 8'h75;
   localparam logic [7:0] CH_SPACE   = 8'h20;

   localparam logic [20:0] CP_REPLACE = 21'h00FFFD;
   localparam logic [20:0] CP_SUPP    = 21'h010000;
   localparam logic [2:0]  LOOK_LAST  = 3'd5;

   logic [2:0]  mode_ff, mode_in;
   logic [15:0] acc_ff, acc_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [9:0]  hi_ff, hi_in;

   logic        is_hex;
   logic [3:0]  digit;

   logic [2:0]  eff_mode;
   logic [15:0] eff_acc;
   logic [2:0]  eff_cnt;
   logic [2:0]  ab_mode;
   logic        look_ok;
   logic [15:0] look_acc;
   logic [15:0] hex_acc;
   logic        prefix;
   logic        run_str;
   logic        fin_en;
   logic [15:0] fin_val;
   logic [2:0]  main_kind;
   logic [7:0]  main_byte;
   logic [20:0] main_cp;
   logic [2:0]  main_err;

   jsu_utf8_type              enc;
   jsu_res_type [3:0]         mres;
   logic [2:0]                mcount;

   // Classify the byte as a hex digit
   always_comb begin
      is_hex = 1'b1;
      digit  = 4'd0;
      if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
         digit = in_byte[3:0];
      end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                   (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
         digit = in_byte[3:0] + 4'd9;
      end else begin
         is_hex = 1'b0;
      end
   end

   // Decide the next state and the results of this transaction
   always_comb begin
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      hi_in     = hi_ff;
      eff_mode  = mode_ff;
      eff_acc   = acc_ff;
      eff_cnt   = cnt_ff;
      prefix    = 1'b0;
      run_str   = 1'b0;
      fin_en    = 1'b0;
      fin_val   = '0;
      hex_acc   = '0;
      main_kind = MK_NONE;
      main_byte = '0;
      main_cp   = '0;
      main_err  = ERR_NONE;

      // Mode implied by the look-ahead bytes held so far
      if (cnt_ff == 3'd0) begin
         ab_mode = M_STR;
      end else if (cnt_ff == 3'd1) begin
         ab_mode = M_ESC;
      end else begin
         ab_mode = M_HEX;
      end

      if (cnt_ff == 3'd0) begin
         look_ok = (in_byte == CH_BSLASH);
      end else if (cnt_ff == 3'd1) begin
         look_ok = (in_byte == CH_LOWER_U);
      end else begin
         look_ok = is_hex;
      end
      look_acc = {acc_ff[11:0], digit};

      if (end_of_input) begin
         // Drop a pending look-ahead, then report where the input stopped
         if (mode_ff == M_LOOK) begin
            prefix   = 1'b1;
            eff_mode = ab_mode;
         end
         case (eff_mode)
            M_WAIT: main_err = ERR_EXP_STRING;
            M_STR:  main_err = ERR_UNTERM_STR;
            M_ESC:  main_err = ERR_UNTERM_ESC;
            M_HEX:  main_err = ERR_BAD_UESC;
            default: main_err = ERR_NONE;
         endcase
         if (main_err != ERR_NONE) begin
            main_kind = MK_ERR;
         end
         mode_in = M_WAIT;
         acc_in  = '0;
         cnt_in  = '0;
         hi_in   = '0;
      end else begin
         case (mode_ff)
            M_WAIT: begin
               if (in_byte == CH_QUOTE) begin
                  mode_in = M_STR;
               end else begin
                  main_kind = MK_ERR;
                  main_err  = ERR_EXP_STRING;
                  mode_in   = M_ERR;
               end
            end
            M_STR, M_ESC, M_HEX: begin
               run_str = 1'b1;
            end
            M_LOOK: begin
               if (!look_ok) begin
                  // Abandon look-ahead and reprocess the byte as string input
                  prefix   = 1'b1;
                  eff_mode = ab_mode;
                  eff_cnt  = cnt_ff - 3'd2;
                  run_str  = 1'b1;
               end else if (cnt_ff != LOOK_LAST) begin
                  cnt_in = cnt_ff + 3'd1;
                  if (cnt_ff >= 3'd2) begin
                     acc_in = look_acc;
                  end
               end else begin
                  cnt_in = '0;
                  acc_in = '0;
                  if (look_acc[15:10] == 6'b110111) begin
                     main_kind = MK_CP;
                     main_cp   = CP_SUPP + {1'b0, hi_ff, look_acc[9:0]};
                     mode_in   = M_STR;
                  end else begin
                     prefix  = 1'b1;
                     fin_en  = 1'b1;
                     fin_val = look_acc;
                  end
               end
            end
            default: begin
            end
         endcase

         if (run_str) begin
            case (eff_mode)
               M_STR: begin
                  mode_in = M_STR;
                  if (in_byte == CH_QUOTE) begin
                     main_kind = MK_DONE;
                     mode_in   = M_DONE;
                  end else if (in_byte == CH_BSLASH) begin
                     mode_in = M_ESC;
                  end else if (in_byte < CH_SPACE) begin
                     main_kind = MK_ERR;
                     main_err  = ERR_CTRL_CHAR;
                     mode_in   = M_ERR;
                  end else begin
                     main_kind = MK_RAW;
                     main_byte = in_byte;
                  end
               end
               M_ESC: begin
                  mode_in   = M_STR;
                  main_kind = MK_RAW;
                  case (in_byte)
                     CH_QUOTE:   main_byte = CH_QUOTE;
                     CH_BSLASH:  main_byte = CH_BSLASH;
                     CH_SLASH:   main_byte = CH_SLASH;
                     CH_LOWER_B: main_byte = 8'h08;
                     CH_LOWER_F: main_byte = 8'h0C;
                     CH_LOWER_N: main_byte = 8'h0A;
                     CH_LOWER_R: main_byte = 8'h0D;
                     CH_LOWER_T: main_byte = 8'h09;
                     CH_LOWER_U: begin
                        main_kind = MK_NONE;
                        mode_in   = M_HEX;
                        acc_in    = '0;
                        cnt_in    = '0;
                     end
                     default: begin
                        main_kind = MK_ERR;
                        main_err  = ERR_BAD_ESC;
                        mode_in   = M_ERR;
                     end
                  endcase
               end
               default: begin
                  // Hex digit of a \u escape
                  if (!is_hex) begin
                     main_kind = MK_ERR;
                     main_err  = ERR_BAD_UESC;
                     mode_in   = M_ERR;
                  end else begin
                     hex_acc = {eff_acc[11:0], digit};
                     if (eff_cnt[1:0] == 2'd3) begin
                        cnt_in  = '0;
                        fin_en  = 1'b1;
                        fin_val = hex_acc;
                     end else begin
                        mode_in = M_HEX;
                        acc_in  = hex_acc;
                        cnt_in  = {1'b0, eff_cnt[1:0]} + 3'd1;
                     end
                  end
               end
            endcase
         end

         // Complete a \u value: hold a high surrogate, replace a lone low one
         if (fin_en) begin
            if (fin_val[15:10] == 6'b110110) begin
               hi_in   = fin_val[9:0];
               acc_in  = '0;
               cnt_in  = '0;
               mode_in = M_LOOK;
            end else begin
               main_kind = MK_CP;
               main_cp   = (fin_val[15:10] == 6'b110111) ? CP_REPLACE : {5'd0, fin_val};
               mode_in   = M_STR;
            end
         end
      end
   end

   // Expand the main result into its entries
   always_comb begin
      enc    = jsu_utf8(main_cp);
      mres   = '0;
      mcount = 3'd0;
      case (main_kind)
         MK_RAW: begin
            mcount  = 3'd1;
            mres[0] = '{out_byte: main_byte, out_kind: KIND_DATA, error_code: ERR_NONE};
         end
         MK_CP: begin
            mcount = enc.len;
            for (int j = 0; j < 4; j++) begin
               mres[j] = '{out_byte: enc.bytes[j], out_kind: KIND_DATA,
                           error_code: ERR_NONE};
            end
         end
         MK_DONE: begin
            mcount  = 3'd1;
            mres[0] = '{out_byte: 8'h00, out_kind: KIND_DONE, error_code: ERR_NONE};
         end
         MK_ERR: begin
            mcount  = 3'd1;
            mres[0] = '{out_byte: 8'h00, out_kind: KIND_ERR, error_code: main_err};
         end
         default: begin
            mcount = 3'd0;
         end
      endcase
   end

   // Place an optional U+FFFD ahead of the main entries
   always_comb begin
      list.slot = '0;
      if (prefix) begin
         list.slot[0] = '{out_byte: 8'hEF, out_kind: KIND_DATA, error_code: ERR_NONE};
         list.slot[1] = '{out_byte: 8'hBF, out_kind: KIND_DATA, error_code: ERR_NONE};
         list.slot[2] = '{out_byte: 8'hBD, out_kind: KIND_DATA, error_code: ERR_NONE};
         list.slot[3] = mres[0];
         list.slot[4] = mres[1];
         list.slot[5] = mres[2];
         list.count   = CountW'(mcount) + CountW'(3);
      end else begin
         list.slot[0] = mres[0];
         list.slot[1] = mres[1];
         list.slot[2] = mres[2];
         list.slot[3] = mres[3];
         list.count   = CountW'(mcount);
      end
   end

   // Advance the parser state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_WAIT;
         acc_ff  <= '0;
         cnt_ff  <= '0;
         hi_ff   <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         hi_ff   <= hi_in;
      end
   end

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && end_of_input |=> mode_ff == M_WAIT)
      else $error("end of input did not return the parser to waiting");

   a_hex_count: assert property (@(posedge clock) disable iff (reset)
      mode_ff == M_HEX |-> cnt_ff <= 3'd3)
      else $error("hex digit count out of range");

   a_look_count: assert property (@(posedge clock) disable iff (reset)
      mode_ff == M_LOOK |-> cnt_ff <= LOOK_LAST)
      else $error("look-ahead position out of range");

endmodule

@@ hw/rtl/jsu_rsp_buf.sv @@
// Result buffer: holds one transaction's result list, drained one entry per ready cycle.
// Depends on jsu_pkg.
module jsu_rsp_buf
   import jsu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  jsu_list_type       list,
   input  logic               rsp_ready,
   output jsu_res_type        rsp_res,
   output jsu_buf_status_type status
);

   jsu_res_type [MaxRes-1:0] bank_ff;
   logic [CountW-1:0]        cnt_ff;
   logic [IdxW-1:0]          rd_ff;
   logic                     fire;

   assign status.valid    = (cnt_ff != '0);
   assign status.last     = (rd_ff == IdxW'(cnt_ff - CountW'(1)));
   assign fire            = status.valid && rsp_ready;
   assign status.can_load = !status.valid || (fire && status.last);
   assign rsp_res         = bank_ff[rd_ff];

   // Hold payload of the current list
   always_ff @(posedge clock) begin
      if (load) begin
         bank_ff <= list.slot;
      end
   end

   // Track fill and read position; empty when the final entry is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= '0;
      end else if (load) begin
         cnt_ff <= list.count;
         rd_ff  <= '0;
      end else if (fire) begin
         if (status.last) begin
            cnt_ff <= '0;
            rd_ff  <= '0;
         end else begin
            rd_ff <= rd_ff + IdxW'(1);
         end
      end
   end

   a_rd_in_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != '0 |-> CountW'(rd_ff) < cnt_ff)
      else $error("read position beyond fill count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CountW'(MaxRes))
      else $error("fill count above buffer depth");

   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      fire && status.last && !load |=> cnt_ff == '0)
      else $error("buffer not empty after final entry taken");

endmodule

@@ hw/rtl/json_string_unescape.sv @@
// JSON string unescaper top level: decoder plus result buffer on valid/ready channels.
// Depends on jsu_pkg, jsu_req_if, jsu_rsp_if, jsu_decode and jsu_rsp_buf.
//
// Decodes one quoted JSON string literal, one input byte per transaction, into UTF-8
// result transactions (data byte, string complete, or error with a code). The parser
// state advances in the cycle a byte is accepted, and all results of that byte are
// written into a six-entry result buffer at once. While the result channel is ready, a
// byte that causes zero or one result does not hold up the input, so the block sustains
// one byte per cycle; a byte that causes several results (up to six, e.g. a \u escape
// that becomes a multi-byte UTF-8 sequence) holds the input while the buffer drains one
// result per cycle. The next byte is accepted in the same cycle as the final result of the
// previous one is taken. The last flag marks the final result of each input byte. An
// end-of-input transaction always returns the parser to waiting for an opening quote.
module json_string_unescape
   import jsu_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   jsu_req_if.sink        req_chan,
   jsu_rsp_if.source      rsp_chan
);

   logic               accept;
   jsu_list_type       list;
   jsu_res_type        rsp_res;
   jsu_buf_status_type status;

   // Take a transaction whenever the buffer is free or frees this cycle
   assign req_chan.ready = status.can_load;
   assign accept         = req_chan.valid && status.can_load;

   jsu_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .in_byte      (req_chan.in_byte),
      .end_of_input (req_chan.end_of_input),
      .list         (list)
   );

   jsu_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .list      (list),
      .rsp_ready (rsp_chan.ready),
      .rsp_res   (rsp_res),
      .status    (status)
   );

   // Drive the result channel from the buffer head
   assign rsp_chan.valid      = status.valid;
   assign rsp_chan.out_byte   = rsp_res.out_byte;
   assign rsp_chan.out_kind   = rsp_res.out_kind;
   assign rsp_chan.error_code = rsp_res.error_code;
   assign rsp_chan.last       = status.last;

endmodule
